### src/csmad_pkg.sv
// Package for the color share moving average detector.
// Holds widths, the window length, word types, controller states and the
// command and status structs, and is used by all modules. No dependencies.
package csmad_pkg;

    localparam int WINDOW    = 8;
    localparam int COUNT_W   = 16;
    localparam int SHARE_W   = 17;
    localparam int WHOLE_W   = COUNT_W + 2;
    localparam int REM_W     = WHOLE_W + 1;
    localparam int LEVEL_W   = 17;
    localparam int TOTAL_W   = 20;
    localparam int SHARE_ONE = 65536;
    localparam int SLOT_W    = $clog2(WINDOW);
    localparam int SUM_W     = $clog2(SHARE_ONE * WINDOW + 1);
    localparam int THR_W     = LEVEL_W + $clog2(WINDOW + 1);
    localparam int CMP_W     = (THR_W > SUM_W) ? THR_W : SUM_W;
    localparam int DIV_STEPS = SHARE_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(32768);

    typedef struct packed {
        logic [COUNT_W-1:0] red_count;
        logic [COUNT_W-1:0] green_count;
        logic [COUNT_W-1:0] blue_count;
    } t_in_word;

    typedef struct packed {
        logic               red_ahead;
        logic               green_ahead;
        logic [TOTAL_W-1:0] red_window_total;
        logic [TOTAL_W-1:0] green_window_total;
    } t_out_word;

    typedef struct packed {
        logic [SHARE_W-1:0] red_share;
        logic [SHARE_W-1:0] green_share;
    } t_hist_word;

    typedef enum logic {
        COLOR_RED,
        COLOR_GREEN
    } t_color;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START_RED,
        ST_WAIT_RED,
        ST_START_GREEN,
        ST_WAIT_GREEN,
        ST_SUM,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic   load_in;
        logic   div_start;
        t_color div_sel;
        logic   sum_calc;
        logic   commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_ctrl_stat;

endpackage

### src/color_share_moving_average_detect.sv
// Top level of the color share moving average detector.
// Depends on csmad_pkg, csmad_ctrl and csmad_dp.
//
// Each input word holds raw red, green and blue counts; each one yields one output word
// with the eight-sample moving totals of the red and green Q1.16 shares and a flag per
// color set when the total exceeds the saturation level times the window length. Both
// shares are formed in turn by the shared one-bit-per-cycle divider (17 steps each);
// the next word is accepted the cycle after a result is registered, even if that
// result is still stalled at the output.
// Reset clears the totals; unwritten ring slots read as zero, with no clearing pass.
// The saturation level may be written at any time the block is idle.
module color_share_moving_average_detect (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  csmad_pkg::t_in_word           i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output csmad_pkg::t_out_word          o_out_word,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [csmad_pkg::LEVEL_W-1:0] i_cfg_data
);

    csmad_pkg::t_ctrl_cmd  cmd;
    csmad_pkg::t_ctrl_stat stat;

    assign o_cfg_ready = 1'b1;

    csmad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    csmad_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid & o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

### src/csmad_div.sv
// Iterative restoring divider for the Q1.16 color share, one quotient bit per cycle.
// Depends on csmad_pkg.
module csmad_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [csmad_pkg::COUNT_W-1:0] i_part,
    input  logic [csmad_pkg::WHOLE_W-1:0] i_whole,
    output logic                          o_done,
    output logic [csmad_pkg::SHARE_W-1:0] o_quot
);

    logic                          r_busy;
    logic                          r_done;
    logic [csmad_pkg::STEP_W-1:0]  r_cnt;
    logic                          r_zero;
    logic [csmad_pkg::REM_W-1:0]   r_rem;
    logic [csmad_pkg::SHARE_W-1:0] r_quot;
    logic [csmad_pkg::REM_W-1:0]   trial;
    logic [csmad_pkg::REM_W:0]     diff;
    logic                          take;

    always_comb begin
        trial = (r_cnt == '0) ? r_rem : {r_rem[csmad_pkg::REM_W-2:0], 1'b0};
        diff  = {1'b0, trial} - (csmad_pkg::REM_W + 1)'(i_whole);
        take  = ~diff[csmad_pkg::REM_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == csmad_pkg::STEP_W'(csmad_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= csmad_pkg::REM_W'(i_part);
            r_quot <= '0;
            r_zero <= (i_whole == '0);
        end else if (r_busy) begin
            r_rem  <= take ? diff[csmad_pkg::REM_W-1:0] : trial;
            r_quot <= {r_quot[csmad_pkg::SHARE_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_zero ? '0 : r_quot;

endmodule

### src/csmad_dp.sv
// Datapath: input word register, shared divider, share ring memory, running
// totals, threshold compare and output word register. Depends on csmad_pkg and csmad_div.
module csmad_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  csmad_pkg::t_ctrl_cmd          i_cmd,
    output csmad_pkg::t_ctrl_stat         o_stat,
    input  csmad_pkg::t_in_word           i_in_word,
    input  logic                          i_cfg_valid,
    input  logic [csmad_pkg::LEVEL_W-1:0] i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output csmad_pkg::t_out_word          o_out_word
);

    csmad_pkg::t_hist_word         mem [csmad_pkg::WINDOW];
    csmad_pkg::t_hist_word         r_rd_data;
    csmad_pkg::t_in_word           r_in;
    logic [csmad_pkg::WHOLE_W-1:0] r_whole;
    logic [csmad_pkg::SHARE_W-1:0] r_red_share;
    logic [csmad_pkg::SHARE_W-1:0] r_green_share;
    logic [csmad_pkg::SUM_W-1:0]   r_red_sum;
    logic [csmad_pkg::SUM_W-1:0]   r_green_sum;
    logic [csmad_pkg::SUM_W-1:0]   r_red_next;
    logic [csmad_pkg::SUM_W-1:0]   r_green_next;
    logic [csmad_pkg::SLOT_W-1:0]  r_slot;
    logic                          r_wrapped;
    logic [csmad_pkg::LEVEL_W-1:0] r_level;
    logic                          r_out_valid;
    csmad_pkg::t_out_word          r_out;
    logic [csmad_pkg::COUNT_W-1:0] div_part;
    logic                          div_done;
    logic [csmad_pkg::SHARE_W-1:0] div_quot;
    logic [csmad_pkg::SHARE_W-1:0] old_red;
    logic [csmad_pkg::SHARE_W-1:0] old_green;
    logic [csmad_pkg::CMP_W-1:0]   threshold;
    logic                          out_free;

    assign div_part = (i_cmd.div_sel == csmad_pkg::COLOR_GREEN) ? r_in.green_count
                                                                 : r_in.red_count;

    csmad_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_part  (div_part),
        .i_whole (r_whole),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Slots not yet written since reset read as zero shares.
    assign old_red   = r_wrapped ? r_rd_data.red_share : '0;
    assign old_green = r_wrapped ? r_rd_data.green_share : '0;
    assign threshold = csmad_pkg::CMP_W'(r_level) * csmad_pkg::CMP_W'(csmad_pkg::WINDOW);
    assign out_free  = ~r_out_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[r_slot];
        if (i_cmd.commit) begin
            mem[r_slot] <= '{red_share: r_red_share, green_share: r_green_share};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in    <= i_in_word;
            r_whole <= csmad_pkg::WHOLE_W'(i_in_word.red_count)
                     + csmad_pkg::WHOLE_W'(i_in_word.green_count)
                     + csmad_pkg::WHOLE_W'(i_in_word.blue_count);
        end
        if (div_done) begin
            if (i_cmd.div_sel == csmad_pkg::COLOR_GREEN) begin
                r_green_share <= div_quot;
            end else begin
                r_red_share <= div_quot;
            end
        end
        if (i_cmd.sum_calc) begin
            r_red_next   <= r_red_sum - csmad_pkg::SUM_W'(old_red)
                          + csmad_pkg::SUM_W'(r_red_share);
            r_green_next <= r_green_sum - csmad_pkg::SUM_W'(old_green)
                          + csmad_pkg::SUM_W'(r_green_share);
        end
        if (i_cmd.commit) begin
            r_out.red_ahead          <= csmad_pkg::CMP_W'(r_red_next) > threshold;
            r_out.green_ahead        <= csmad_pkg::CMP_W'(r_green_next) > threshold;
            r_out.red_window_total   <= csmad_pkg::TOTAL_W'(r_red_next);
            r_out.green_window_total <= csmad_pkg::TOTAL_W'(r_green_next);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_sum   <= '0;
            r_green_sum <= '0;
            r_slot      <= '0;
            r_wrapped   <= 1'b0;
            r_level     <= csmad_pkg::LEVEL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_level <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_red_sum   <= r_red_next;
                r_green_sum <= r_green_next;
                r_out_valid <= 1'b1;
                if (r_slot == csmad_pkg::SLOT_W'(csmad_pkg::WINDOW - 1)) begin
                    r_slot    <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_slot <= r_slot + 1'b1;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.div_done = div_done;
    assign o_stat.out_free = out_free;
    assign o_out_valid     = r_out_valid;
    assign o_out_word      = r_out;

endmodule

### src/csmad_ctrl.sv
// Controller state machine that sequences one word through the datapath.
// Depends on csmad_pkg.
module csmad_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  csmad_pkg::t_ctrl_stat i_stat,
    output csmad_pkg::t_ctrl_cmd  o_cmd
);

    csmad_pkg::t_state r_state;
    csmad_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= csmad_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd.load_in   = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.div_sel   = csmad_pkg::COLOR_RED;
        o_cmd.sum_calc  = 1'b0;
        o_cmd.commit    = 1'b0;
        o_in_stall      = 1'b1;
        unique case (r_state)
            csmad_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = csmad_pkg::ST_START_RED;
                end
            end
            csmad_pkg::ST_START_RED: begin
                o_cmd.div_start = 1'b1;
                n_state         = csmad_pkg::ST_WAIT_RED;
            end
            csmad_pkg::ST_WAIT_RED: begin
                if (i_stat.div_done) begin
                    n_state = csmad_pkg::ST_START_GREEN;
                end
            end
            csmad_pkg::ST_START_GREEN: begin
                o_cmd.div_sel   = csmad_pkg::COLOR_GREEN;
                o_cmd.div_start = 1'b1;
                n_state         = csmad_pkg::ST_WAIT_GREEN;
            end
            csmad_pkg::ST_WAIT_GREEN: begin
                o_cmd.div_sel = csmad_pkg::COLOR_GREEN;
                if (i_stat.div_done) begin
                    n_state = csmad_pkg::ST_SUM;
                end
            end
            csmad_pkg::ST_SUM: begin
                o_cmd.sum_calc = 1'b1;
                n_state        = csmad_pkg::ST_COMMIT;
            end
            csmad_pkg::ST_COMMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = csmad_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = csmad_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### src/csmad_chk.sv
// Port-level checker for the color share moving average detector, bound to the top level.
// Depends on csmad_pkg.
module csmad_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_stall,
    input csmad_pkg::t_in_word           i_in_word,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input csmad_pkg::t_out_word          o_out_word
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("Stalled output word was dropped or changed.");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_word))
        else $error("Stalled input word was dropped or changed.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("Input was not stalled while a word is in progress.");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("Output word appeared while the block was idle.");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> !$rose(o_out_valid))
        else $error("Output word appeared right after input acceptance.");

endmodule

bind color_share_moving_average_detect csmad_chk u_csmad_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
